@@ rtl/ilt_pkg.sv @@
package ilt_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int FIELD_W = 7;
    localparam int OPER_W  = 3;
    localparam int ERR_W   = 3;

    typedef enum logic [OPER_W-1:0] {
        OP_GET        = 3'd0,
        OP_SET        = 3'd1,
        OP_APPEND     = 3'd2,
        OP_INSERT     = 3'd3,
        OP_REMOVE_AT  = 3'd4,
        OP_REMOVE_VAL = 3'd5,
        OP_FIND       = 3'd6
    } oper_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 3'd0,
        ERR_NEG       = 3'd1,
        ERR_OOB       = 3'd2,
        ERR_CAP       = 3'd3,
        ERR_NOT_FOUND = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           kind;
        logic               match_en;
        logic [VALUE_W-1:0] value;
    } cell_ctrl_t;

    localparam logic [FIELD_W-1:0] NO_MATCH = '1;

endpackage

@@ rtl/ilt_cell.sv @@
module ilt_cell
    import ilt_pkg::*;
#(
    parameter int CW  = 7,
    parameter int POS = 0
)
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic [CW-1:0]      pos,
    input  logic [CW-1:0]      count,
    input  logic [VALUE_W-1:0] left_data,
    input  logic [VALUE_W-1:0] right_data,
    output logic [VALUE_W-1:0] data,
    output logic               match,
    output logic [VALUE_W-1:0] sel_data
);

    localparam logic [CW-1:0] POS_W = CW'(POS);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               match_reg;
    logic               match_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.kind)
            CELL_WRITE:
            begin
                if (POS_W == pos)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_INSERT:
            begin
                if (POS_W == pos)
                begin
                    data_next = ctrl.value;
                end
                else if (POS_W > pos)
                begin
                    data_next = left_data;
                end
            end
            CELL_REMOVE:
            begin
                if (POS_W >= pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // capture compare only for live entries
    assign match_next = ctrl.match_en ? ((POS_W < count) && (data_reg == ctrl.value))
                                      : match_reg;

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data     = data_reg;
    assign match    = match_reg;
    assign sel_data = (POS_W == pos) ? data_reg : '0;

endmodule

@@ rtl/indexed_list_table.sv @@
// Ordered list of 32-bit entries held in a row of DEPTH cells, one entry per
// cell. Each beat on s_* carries one request (get, set, append, insert,
// remove at index, remove value, find) and produces exactly one result beat
// on m_*. A request moves through ST_IDLE, in which it is accepted and
// latched, ST_MATCH, in which every cell compares its entry with the key
// and registers the hit, and ST_EXEC, in which the first hit is encoded and
// the cells write or shift in a single step. s_tready rises at the same
// edge that loads the result, so no new request is accepted before the
// last one's result is loaded. While a result waits, a new request is
// still accepted and compared, then held in ST_EXEC until the result
// register frees up. Entries are not cleared at reset; only positions below
// the current size are ever read. Write capacity only while no request is in
// flight.
module indexed_list_table
    import ilt_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // capacity_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // operation[2:0], index[10:3], item_value[42:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata        // read_value[31:0], found_index[38:32],
                                       // list_len[45:39], error_code[48:46]
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam logic [CMPW-1:0] DEPTH_W = CMPW'(DEPTH);

    state_t state_reg;
    state_t state_next;

    logic [OPER_W-1:0]  req_op_reg;
    logic [INDEX_W-1:0] req_index_reg;
    logic [VALUE_W-1:0] req_value_reg;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [FIELD_W-1:0] cap_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_read_reg;
    logic [FIELD_W-1:0] out_found_reg;
    logic [FIELD_W-1:0] out_size_reg;
    err_t               out_err_reg;

    logic               out_load;
    logic               can_load;
    logic [VALUE_W-1:0] read_next;
    logic [FIELD_W-1:0] found_next;
    err_t               err_next;

    cell_ctrl_t         ctrl;
    logic [CW-1:0]      cell_pos;

    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [VALUE_W-1:0] cell_sel  [DEPTH];
    logic [DEPTH-1:0]   match_vec;
    logic [DEPTH-1:0]   first_hot;
    logic [IW-1:0]      first_idx;
    logic               any_match;
    logic [VALUE_W-1:0] hit_data;

    logic               idx_neg;
    logic [CMPW-1:0]    pos_w;
    logic [CMPW-1:0]    cnt_w;
    logic               full;
    logic [CW-1:0]      req_pos;

    // row of cells
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [VALUE_W-1:0] left_in;
            logic [VALUE_W-1:0] right_in;
            if (g == 0)
            begin : g_first
                assign left_in = ctrl.value;
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[g+1];
            end

            ilt_cell #(
                .CW  (CW),
                .POS (g)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .pos        (cell_pos),
                .count      (count_reg),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[g]),
                .match      (match_vec[g]),
                .sel_data   (cell_sel[g])
            );
        end
    endgenerate

    // isolate lowest hit, then encode
    assign first_hot = match_vec & (~match_vec + 1'b1);
    assign any_match = |match_vec;

    always_comb
    begin
        first_idx = '0;
        hit_data  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            first_idx = first_idx | (first_hot[i] ? IW'(i) : '0);
            hit_data  = hit_data | cell_sel[i];
        end
    end

    assign idx_neg  = req_index_reg[INDEX_W-1];
    assign pos_w    = CMPW'(req_index_reg[INDEX_W-2:0]);
    assign cnt_w    = CMPW'(count_reg);
    assign full     = (cnt_w >= DEPTH_W) || (cnt_w >= CMPW'(cap_reg));
    assign req_pos  = CW'(req_index_reg[INDEX_W-2:0]);
    assign can_load = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and request execution
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        ctrl.kind     = CELL_HOLD;
        ctrl.match_en = (state_reg == ST_MATCH);
        ctrl.value    = req_value_reg;
        cell_pos      = req_pos;
        count_next    = count_reg;
        read_next     = '0;
        found_next    = NO_MATCH;
        err_next      = ERR_OK;
        out_load      = (state_reg == ST_EXEC) && can_load;

        if (out_load)
        begin
            case (oper_t'(req_op_reg))
                OP_GET, OP_SET, OP_REMOVE_AT:
                begin
                    if (idx_neg)
                    begin
                        err_next = ERR_NEG;
                    end
                    else if (pos_w >= cnt_w)
                    begin
                        err_next = ERR_OOB;
                    end
                    else if (req_op_reg == OP_GET)
                    begin
                        read_next = hit_data;
                    end
                    else if (req_op_reg == OP_SET)
                    begin
                        ctrl.kind = CELL_WRITE;
                    end
                    else
                    begin
                        ctrl.kind  = CELL_REMOVE;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_APPEND:
                begin
                    if (full)
                    begin
                        err_next = ERR_CAP;
                    end
                    else
                    begin
                        ctrl.kind  = CELL_WRITE;
                        cell_pos   = count_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_INSERT:
                begin
                    if (idx_neg)
                    begin
                        err_next = ERR_NEG;
                    end
                    else if (pos_w > cnt_w)
                    begin
                        err_next = ERR_OOB;
                    end
                    else if (full)
                    begin
                        err_next = ERR_CAP;
                    end
                    else
                    begin
                        ctrl.kind  = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_REMOVE_VAL, OP_FIND:
                begin
                    if (!any_match)
                    begin
                        err_next = ERR_NOT_FOUND;
                    end
                    else
                    begin
                        found_next = FIELD_W'(first_idx);
                        if (req_op_reg == OP_REMOVE_VAL)
                        begin
                            ctrl.kind  = CELL_REMOVE;
                            cell_pos   = CW'(first_idx);
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    err_next = ERR_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= 7'd64;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_op_reg    <= s_tdata[2:0];
            req_index_reg <= s_tdata[10:3];
            req_value_reg <= s_tdata[42:11];
        end
        if (out_load)
        begin
            out_read_reg  <= read_next;
            out_found_reg <= found_next;
            out_size_reg  <= FIELD_W'(count_next);
            out_err_reg   <= err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_err_reg, out_size_reg, out_found_reg, out_read_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= DEPTH_W)
        else $error("list size exceeds cell count");

    a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_MATCH))
        else $error("accepted beat did not enter compare cycle");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1)
        || (count_reg == $past(count_reg) - 1'b1))
        else $error("list size moved by more than one");

    a_error_keeps_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (err_next != ERR_OK)) |=> (count_reg == $past(count_reg)))
        else $error("failed request changed list size");

endmodule

@@ dv/tb_indexed_list_table.sv @@
`timescale 1ns / 1ps

module tb_indexed_list_table
    import ilt_pkg::*;
;

    localparam int          LIST_DEPTH  = 64;
    localparam int          CYCLE_LIMIT = 300000;
    localparam logic [2:0]  OP_NOP      = 3'd7;

    typedef struct packed {
        logic [31:0] read_value;
        logic [6:0]  found_index;
        logic [6:0]  list_len;
        logic [2:0]  error_code;
    } table_result_t;

    typedef struct packed {
        logic [2:0]    op;
        logic [7:0]    idx;
        logic [31:0]   val;
        logic          typed;
        table_result_t want;
    } request_row_t;

    // Typed-in results only where they follow at a glance; the rest go through the predictor
    localparam request_row_t DIRECTED_ROWS [24] = '{
        '{OP_GET,        8'h00, 32'h0,        1'b1, '{32'h0, NO_MATCH, 7'd0, ERR_OOB}},
        '{OP_REMOVE_AT,  8'h00, 32'h0,        1'b1, '{32'h0, NO_MATCH, 7'd0, ERR_OOB}},
        '{OP_GET,        8'h80, 32'h0,        1'b1, '{32'h0, NO_MATCH, 7'd0, ERR_NEG}},
        '{OP_FIND,       8'h00, 32'h0,        1'b1, '{32'h0, NO_MATCH, 7'd0, ERR_NOT_FOUND}},
        '{OP_REMOVE_VAL, 8'h00, 32'hFFFFFFFF, 1'b1, '{32'h0, NO_MATCH, 7'd0, ERR_NOT_FOUND}},
        '{OP_INSERT,     8'h01, 32'h5,        1'b1, '{32'h0, NO_MATCH, 7'd0, ERR_OOB}},
        '{OP_INSERT,     8'hFF, 32'h5,        1'b1, '{32'h0, NO_MATCH, 7'd0, ERR_NEG}},
        '{OP_INSERT,     8'h00, 32'hFFFFFFFF, 1'b1, '{32'h0, NO_MATCH, 7'd1, ERR_OK}},
        '{OP_APPEND,     8'h00, 32'h0,        1'b1, '{32'h0, NO_MATCH, 7'd2, ERR_OK}},
        '{OP_APPEND,     8'h7F, 32'h12345678, 1'b1, '{32'h0, NO_MATCH, 7'd3, ERR_OK}},
        '{OP_INSERT,     8'h01, 32'hAAAAAAAA, 1'b1, '{32'h0, NO_MATCH, 7'd4, ERR_OK}},
        '{OP_GET,        8'h01, 32'h0,        1'b1, '{32'hAAAAAAAA, NO_MATCH, 7'd4, ERR_OK}},
        '{OP_SET,        8'h03, 32'h55555555, 1'b1, '{32'h0, NO_MATCH, 7'd4, ERR_OK}},
        '{OP_SET,        8'h04, 32'h1,        1'b1, '{32'h0, NO_MATCH, 7'd4, ERR_OOB}},
        '{OP_GET,        8'h7F, 32'h0,        1'b1, '{32'h0, NO_MATCH, 7'd4, ERR_OOB}},
        '{OP_FIND,       8'h00, 32'h0,        1'b1, '{32'h0, 7'd2, 7'd4, ERR_OK}},
        '{OP_NOP,        8'h80, 32'hFFFFFFFF, 1'b1, '{32'h0, NO_MATCH, 7'd4, ERR_OK}},
        '{OP_REMOVE_VAL, 8'h00, 32'hAAAAAAAA, 1'b0, '0},
        '{OP_REMOVE_AT,  8'h00, 32'h0,        1'b0, '0},
        '{OP_GET,        8'h00, 32'h0,        1'b0, '0},
        '{OP_INSERT,     8'h02, 32'h1,        1'b0, '0},
        '{OP_REMOVE_AT,  8'h80, 32'h0,        1'b0, '0},
        '{OP_GET,        8'h02, 32'h0,        1'b0, '0},
        '{OP_FIND,       8'h00, 32'h55555555, 1'b0, '0}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [6:0]  cfg_wr_data = 7'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = 48'd0;   // operation[2:0], index[10:3], item_value[42:11]
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [55:0] m_tdata;               // read_value[31:0], found_index[38:32],
                                        // list_len[45:39], error_code[48:46]

    // Shadow copy of the list
    logic [31:0] list_store [LIST_DEPTH];
    int          list_count;
    int          capacity_reg;

    table_result_t pending_results [$];

    int send_idle_pct;
    int rcv_stall_pct;
    int n_requests;
    int n_checked;
    int n_errors;
    int n_cap_writes;
    int peak_size;
    int cycle_count;
    int err_hits [8];

    indexed_list_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic void drop_entry(input int pos);
        for (int i = pos; i < list_count - 1; i++)
        begin
            list_store[i] = list_store[i + 1];
        end
        list_count--;
    endfunction

    function automatic table_result_t apply_request(input logic [2:0] op,
                                                    input logic signed [7:0] idx,
                                                    input logic [31:0] val);
        table_result_t r;
        int pos;
        int hit;
        int cap;
        r.read_value  = 32'd0;
        r.found_index = NO_MATCH;
        r.error_code  = ERR_OK;
        pos = int'(idx);
        cap = (capacity_reg > LIST_DEPTH) ? LIST_DEPTH : capacity_reg;
        case (op)
            OP_GET, OP_SET, OP_REMOVE_AT:
            begin
                if (pos < 0)
                    r.error_code = ERR_NEG;
                else if (pos >= list_count)
                    r.error_code = ERR_OOB;
                else if (op == OP_GET)
                    r.read_value = list_store[pos];
                else if (op == OP_SET)
                    list_store[pos] = val;
                else
                    drop_entry(pos);
            end
            OP_APPEND:
            begin
                if (list_count >= cap)
                    r.error_code = ERR_CAP;
                else
                begin
                    list_store[list_count] = val;
                    list_count++;
                end
            end
            OP_INSERT:
            begin
                if (pos < 0)
                    r.error_code = ERR_NEG;
                else if (pos > list_count)
                    r.error_code = ERR_OOB;
                else if (list_count >= cap)
                    r.error_code = ERR_CAP;
                else
                begin
                    for (int i = list_count; i > pos; i--)
                    begin
                        list_store[i] = list_store[i - 1];
                    end
                    list_store[pos] = val;
                    list_count++;
                end
            end
            OP_REMOVE_VAL, OP_FIND:
            begin
                hit = -1;
                for (int i = 0; i < list_count; i++)
                begin
                    if (hit < 0 && list_store[i] == val)
                        hit = i;
                end
                if (hit < 0)
                    r.error_code = ERR_NOT_FOUND;
                else
                begin
                    r.found_index = hit[6:0];
                    if (op == OP_REMOVE_VAL)
                        drop_entry(hit);
                end
            end
            default:
            begin
            end
        endcase
        r.list_len = list_count[6:0];
        if (list_count > peak_size)
            peak_size = list_count;
        return r;
    endfunction

    function automatic logic [2:0] pick_op(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow)
        begin
            if (r < 15) return OP_GET;
            if (r < 25) return OP_SET;
            if (r < 45) return OP_APPEND;
            if (r < 65) return OP_INSERT;
            if (r < 77) return OP_REMOVE_AT;
            if (r < 87) return OP_REMOVE_VAL;
            if (r < 97) return OP_FIND;
        end
        else
        begin
            if (r < 12) return OP_GET;
            if (r < 20) return OP_SET;
            if (r < 28) return OP_APPEND;
            if (r < 36) return OP_INSERT;
            if (r < 62) return OP_REMOVE_AT;
            if (r < 82) return OP_REMOVE_VAL;
            if (r < 97) return OP_FIND;
        end
        return OP_NOP;
    endfunction

    function automatic logic [7:0] pick_index();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 8'(-int'($urandom_range(1, 128)));
        if (k == 1)
            return 8'($urandom);
        // mostly land on a live position or one past the end
        return 8'($urandom_range(0, list_count));
    endfunction

    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4 && list_count > 0)
            return list_store[$urandom_range(0, list_count - 1)];
        if (k < 7)
            return 32'($urandom_range(0, 7));
        if (k == 7)
            return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
        return $urandom;
    endfunction

    task automatic send_req(input logic [2:0] op, input logic signed [7:0] idx,
                            input logic [31:0] val, input logic typed,
                            input table_result_t want);
        table_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, val, idx, op};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_request(op, idx, val);
        pending_results.push_back(typed ? want : predicted);
        n_requests++;
    endtask

    task automatic write_capacity(input int cap);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 7'(cap);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_reg = cap;
        n_cap_writes++;
    endtask

    task automatic run_phase(input int cap, input int send_pct, input int stall_pct,
                             input int n_items, input bit grow);
        logic [2:0] op;
        s_tvalid <= 1'b0;
        write_capacity(cap);
        send_idle_pct = send_pct;
        rcv_stall_pct = stall_pct;
        repeat (n_items)
        begin
            op = pick_op(grow);
            send_req(op, pick_index(), pick_value(), 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        table_result_t oldest;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing pending, expected none, actual %h",
                         $time, m_tdata);
                n_errors++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("read_value", oldest.read_value, m_tdata[31:0]);
                check_field("found_index", 32'(oldest.found_index), 32'(m_tdata[38:32]));
                check_field("list_len", 32'(oldest.list_len), 32'(m_tdata[45:39]));
                check_field("error_code", 32'(oldest.error_code), 32'(m_tdata[48:46]));
                err_hits[m_tdata[48:46]]++;
                n_checked++;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results pending", $time, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            list_store[i] = 32'd0;
        end
        list_count    = 0;
        capacity_reg  = 64;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            send_req(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].val,
                     DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        // fill to the limit, then vary capacity around and below the live size
        run_phase(64, 0, 0, 160, 1'b1);
        run_phase(127, 59, 0, 140, 1'b1);
        run_phase(1, 0, 59, 100, 1'b0);
        run_phase(0, 10, 10, 80, 1'b1);
        run_phase($urandom_range(2, 63), 0, 0, 140, 1'b0);
        run_phase(20, 59, 0, 140, 1'b1);
        run_phase(64, 10, 10, 140, 1'b0);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d requests across %0d capacity settings, %0d results checked",
                 n_requests, n_cap_writes + 1, n_checked);
        $display("list size peaked at %0d; capacity errors %0d, index errors %0d, misses %0d",
                 peak_size, err_hits[ERR_CAP], err_hits[ERR_NEG] + err_hits[ERR_OOB],
                 err_hits[ERR_NOT_FOUND]);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ indexed_list_table.f @@
rtl/ilt_pkg.sv
rtl/ilt_cell.sv
rtl/indexed_list_table.sv
dv/tb_indexed_list_table.sv
